@@ rtl/dllw_pkg.sv @@
// shared types and constants for the dma linked list length walker
// no dependencies

package dllw_pkg;

    localparam int RAM_ADDR_BITS_DEFAULT = 21;

    localparam int CMD_W        = 1;
    localparam int START_ADDR_W = 24;
    localparam int HEADER_W     = 32;
    localparam int FETCH_ADDR_W = 21;
    localparam int SIZE_W       = 32;
    localparam int LIMIT_W      = 22;
    localparam int COUNT_W      = 23;
    localparam int PTR_W        = 24;

    localparam logic [LIMIT_W-1:0] NODE_LIMIT_RESET = 22'd2000000;
    localparam logic [PTR_W-1:0]   END_MARK         = 24'hFFFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 23'h7FFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 1'b0,
        CMD_HEADER = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        END_RUNNING = 2'd0,
        END_MARKER  = 2'd1,
        END_LOOP    = 2'd2,
        END_LIMIT   = 2'd3
    } end_cause_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [START_ADDR_W-1:0] start_addr;
        logic [HEADER_W-1:0]     header_word;
    } item_t;

    typedef struct packed {
        logic [FETCH_ADDR_W-1:0] fetch_addr;
        logic                    done_res;
        logic [SIZE_W-1:0]       total_size;
        end_cause_t              end_cause;
    } result_t;

endpackage

@@ rtl/dllw_in_reg.sv @@
// input register stage for the walker
// depends on dllw_pkg

module dllw_in_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dllw_pkg::item_t in_item,
    input  logic          advance,
    output logic          item_valid,
    output dllw_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    dllw_pkg::item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/dllw_walk_core.sv @@
// walk state, node limit register, loop check and size accumulation
// depends on dllw_pkg

module dllw_walk_core
#(
    parameter int RAM_ADDR_BITS = dllw_pkg::RAM_ADDR_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dllw_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic                          fire,
    input  dllw_pkg::item_t               item,
    output dllw_pkg::result_t             result
);

    localparam logic [dllw_pkg::PTR_W-1:0] ADDR_MASK =
        dllw_pkg::PTR_W'(((1 << RAM_ADDR_BITS) - 1) & ~3);

    logic [dllw_pkg::LIMIT_W-1:0] node_limit_reg;
    logic [RAM_ADDR_BITS-1:0]     current_addr_reg, current_addr_next;
    logic [dllw_pkg::PTR_W-1:0]   last_addr_reg, last_addr_next;
    logic [dllw_pkg::PTR_W-1:0]   lower_mark_reg, lower_mark_next;
    logic [dllw_pkg::PTR_W-1:0]   upper_mark_reg, upper_mark_next;
    logic [dllw_pkg::SIZE_W-1:0]  size_total_reg, size_total_next;
    logic [dllw_pkg::COUNT_W-1:0] node_count_reg, node_count_next;
    logic                         walking_reg, walking_next;

    logic                         is_start;
    logic [dllw_pkg::PTR_W-1:0]   v_last, v_lower, v_upper;
    logic [dllw_pkg::COUNT_W-1:0] v_count;
    logic [dllw_pkg::PTR_W-1:0]   next_ptr;
    logic [dllw_pkg::PTR_W-1:0]   visit_addr;
    logic [dllw_pkg::SIZE_W:0]    size_sum;
    logic [dllw_pkg::SIZE_W-1:0]  size_sat;
    logic [dllw_pkg::PTR_W-1:0]   cur_ext;
    dllw_pkg::end_cause_t         cause;

    assign is_start = (item.cmd == dllw_pkg::CMD_START);
    assign v_last   = is_start ? dllw_pkg::END_MARK : last_addr_reg;
    assign v_lower  = is_start ? dllw_pkg::END_MARK : lower_mark_reg;
    assign v_upper  = is_start ? dllw_pkg::END_MARK : upper_mark_reg;
    assign v_count  = is_start ? '0 : node_count_reg;
    assign next_ptr = item.header_word[dllw_pkg::PTR_W-1:0];

    assign visit_addr = (is_start ? item.start_addr : next_ptr) & ADDR_MASK;

    // size grows by word count plus the pointer word
    assign size_sum = (dllw_pkg::SIZE_W + 1)'(size_total_reg)
                    + (dllw_pkg::SIZE_W + 1)'(item.header_word[31:24])
                    + (dllw_pkg::SIZE_W + 1)'(1);
    assign size_sat = size_sum[dllw_pkg::SIZE_W] ? '1 : size_sum[dllw_pkg::SIZE_W-1:0];

    always_comb
    begin
        current_addr_next = current_addr_reg;
        last_addr_next    = last_addr_reg;
        lower_mark_next   = lower_mark_reg;
        upper_mark_next   = upper_mark_reg;
        size_total_next   = size_total_reg;
        node_count_next   = node_count_reg;
        walking_next      = walking_reg;
        cause             = dllw_pkg::END_RUNNING;

        if (fire && (is_start || walking_reg))
        begin
            last_addr_next  = v_last;
            lower_mark_next = v_lower;
            upper_mark_next = v_upper;
            node_count_next = v_count;
            walking_next    = 1'b1;
            size_total_next = is_start ? dllw_pkg::SIZE_W'(1) : size_sat;

            if (!is_start && (next_ptr == dllw_pkg::END_MARK))
            begin
                cause = dllw_pkg::END_MARKER;
            end
            else
            begin
                if (v_count < dllw_pkg::COUNT_MAX)
                begin
                    node_count_next = v_count + 1'b1;
                end

                priority if (v_count > dllw_pkg::COUNT_W'(node_limit_reg))
                begin
                    cause = dllw_pkg::END_LIMIT;
                end
                else if ((visit_addr == v_lower) || (visit_addr == v_upper))
                begin
                    cause = dllw_pkg::END_LOOP;
                end
                else
                begin
                    if (visit_addr < v_last)
                    begin
                        lower_mark_next = visit_addr;
                    end
                    else
                    begin
                        upper_mark_next = visit_addr;
                    end
                    last_addr_next    = visit_addr;
                    current_addr_next = visit_addr[RAM_ADDR_BITS-1:0];
                end
            end

            if (cause != dllw_pkg::END_RUNNING)
            begin
                walking_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_limit_reg   <= dllw_pkg::NODE_LIMIT_RESET;
            current_addr_reg <= '0;
            last_addr_reg    <= dllw_pkg::END_MARK;
            lower_mark_reg   <= dllw_pkg::END_MARK;
            upper_mark_reg   <= dllw_pkg::END_MARK;
            size_total_reg   <= '0;
            node_count_reg   <= '0;
            walking_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_limit_reg <= cfg_wdata;
            end
            current_addr_reg <= current_addr_next;
            last_addr_reg    <= last_addr_next;
            lower_mark_reg   <= lower_mark_next;
            upper_mark_reg   <= upper_mark_next;
            size_total_reg   <= size_total_next;
            node_count_reg   <= node_count_next;
            walking_reg      <= walking_next;
        end
    end

    assign cur_ext = dllw_pkg::PTR_W'(current_addr_next);

    assign result.fetch_addr = walking_next ? cur_ext[dllw_pkg::FETCH_ADDR_W-1:0] : '0;
    assign result.done_res   = !walking_next;
    assign result.total_size = size_total_next;
    assign result.end_cause  = cause;

endmodule

@@ rtl/dllw_out_reg.sv @@
// result register stage for the walker
// depends on dllw_pkg

module dllw_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  dllw_pkg::result_t result,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_stall,
    output dllw_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    dllw_pkg::result_t result_reg;

    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

@@ rtl/dma_linked_list_length_walker.sv @@
// top level of the dma linked list length walker
// depends on dllw_pkg, dllw_in_reg, dllw_walk_core, dllw_out_reg
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid / in_stall | cmd, start_addr, header_word
//  out     | out_valid/out_stall | fetch_addr, done_res, total_size, end_cause
//  cfg     | cfg_we              | cfg_wdata (node_limit)
//
// one transaction per cycle while out_stall is low; a result is registered in the input then the result register
// the whole node step is one pass of logic between the input and result registers
// reset clears the walk state and loads the default node limit, no clearing pass
// a stalled result holds; input keeps flowing while the input register can drain

module dma_linked_list_length_walker
#(
    parameter int RAM_ADDR_BITS = dllw_pkg::RAM_ADDR_BITS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dllw_pkg::LIMIT_W-1:0]       cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [dllw_pkg::CMD_W-1:0]         cmd,
    input  logic [dllw_pkg::START_ADDR_W-1:0]  start_addr,
    input  logic [dllw_pkg::HEADER_W-1:0]      header_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [dllw_pkg::FETCH_ADDR_W-1:0]  fetch_addr,
    output logic                               done_res,
    output logic [dllw_pkg::SIZE_W-1:0]        total_size,
    output logic [1:0]                         end_cause
);

    dllw_pkg::item_t   in_item;
    dllw_pkg::item_t   item;
    dllw_pkg::result_t result;
    dllw_pkg::result_t out_result;
    logic              item_valid;
    logic              advance;

    assign in_item.cmd         = dllw_pkg::cmd_t'(cmd);
    assign in_item.start_addr  = start_addr;
    assign in_item.header_word = header_word;

    dllw_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dllw_walk_core #(
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    ) u_walk_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (item_valid && advance),
        .item      (item),
        .result    (result)
    );

    dllw_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign fetch_addr = out_result.fetch_addr;
    assign done_res   = out_result.done_res;
    assign total_size = out_result.total_size;
    assign end_cause  = out_result.end_cause;

endmodule

@@ rtl/dllw_checker.sv @@
// port level checks for the dma linked list length walker, bound to the top level
// depends on dllw_pkg and dma_linked_list_length_walker

module dllw_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [dllw_pkg::FETCH_ADDR_W-1:0]  fetch_addr,
    input logic                               done_res,
    input logic [dllw_pkg::SIZE_W-1:0]        total_size,
    input logic [1:0]                         end_cause
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fetch_addr) && $stable(done_res)
            && $stable(total_size) && $stable(end_cause))
        else $error("stalled result changed");

    a_done_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> fetch_addr == '0)
        else $error("fetch address given after walk ended");

    a_running_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> end_cause == dllw_pkg::END_RUNNING)
        else $error("end cause reported while still walking");

    a_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fetch_addr[1:0] == 2'b00)
        else $error("fetch address not word aligned");

    a_running_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> total_size != '0)
        else $error("running walk shows empty size");

endmodule

bind dma_linked_list_length_walker dllw_checker u_dllw_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .fetch_addr (fetch_addr),
    .done_res   (done_res),
    .total_size (total_size),
    .end_cause  (end_cause)
);
